// ===== rtl/cpi_pkg.sv =====
package cpi_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int PHASE_SHIFT  = 32 - ANGLE_BITS;
  localparam int LANES        = 4;
  localparam int CORDIC_ITERS = 30;
  localparam int QUEUE_DEPTH  = 2;

  localparam int LANE_ALPHA = 0;
  localparam int LANE_BETA  = 1;
  localparam int LANE_GAMMA = 2;
  localparam int LANE_DELTA = 3;

  localparam logic [31:0]        FOCAL_RESET = 32'd65536;
  localparam logic signed [32:0] CORDIC_X0   = 33'sd652032874;
  localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;

  typedef struct packed {
    logic                  start;
    logic [LANES-1:0][1:0] quad;
    logic [LANES-1:0][31:0] z0;
    logic [2:0][31:0]      shift;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_MUL,
    ST_FIN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    GRP_TRIG,
    GRP_RM,
    GRP_TR,
    GRP_CEN
  } grp_e;

  typedef struct packed {
    grp_e       grp;
    logic [3:0] idx;
    logic [1:0] k;
    logic       half;
  } op_t;

  localparam logic [3:0] TOP_P1 = 4'd0;
  localparam logic [3:0] TOP_P2 = 4'd1;
  localparam logic [3:0] TOP_M2 = 4'd2;
  localparam logic [3:0] TOP_M0 = 4'd3;
  localparam logic [3:0] TOP_M1 = 4'd4;
  localparam logic [3:0] TOP_M3 = 4'd5;
  localparam logic [3:0] TOP_M4 = 4'd6;
  localparam logic [3:0] TOP_M5 = 4'd7;
  localparam logic [3:0] TOP_M6 = 4'd8;
  localparam logic [3:0] TOP_M7 = 4'd9;

  localparam op_t OP_FIRST = '{grp: GRP_TRIG, idx: 4'd0, k: 2'd0, half: 1'b0};
  localparam op_t OP_LAST  = '{grp: GRP_CEN,  idx: 4'd2, k: 2'd2, half: 1'b1};

  function automatic logic [31:0] atan_at(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] row_of(input logic [3:0] e);
    logic [1:0] r;
    case (e)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] col_of(input logic [3:0] e);
    logic [1:0] c;
    case (e)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] ent(input logic [1:0] r, input logic [1:0] c);
    return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
  endfunction

endpackage

// ===== rtl/camera_pose_integrator.sv =====
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o    start flag, three angles, three shifts
// out      output     out_valid_o / out_stall_i  nine axis components, three centre words
// cfg      input      cfg_valid_i / cfg_ready_o  focal_scale (cfg_data_i)
//
// For each motion, 30 CORDIC steps run on four lanes at once, then
// 58 products share one 34x34 multiplier.
// A two-entry queue takes new motions while the back end works or its result waits.
// Reset (asynchronous, active low) sets the rotation to identity, the centre to zero
// and focal_scale to 1.0; no clearing pass follows.
module camera_pose_integrator import cpi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_new_track_i,
  input  logic [15:0] angle_alpha_i,
  input  logic [15:0] angle_beta_i,
  input  logic [15:0] angle_gamma_i,
  input  logic [31:0] shift_a_i,
  input  logic [31:0] shift_b_i,
  input  logic [31:0] shift_c_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] axis_i_x_o,
  output logic [31:0] axis_i_y_o,
  output logic [31:0] axis_i_z_o,
  output logic [31:0] axis_j_x_o,
  output logic [31:0] axis_j_y_o,
  output logic [31:0] axis_j_z_o,
  output logic [31:0] axis_k_x_o,
  output logic [31:0] axis_k_y_o,
  output logic [31:0] axis_k_z_o,
  output logic [47:0] centre_x_o,
  output logic [47:0] centre_y_o,
  output logic [47:0] centre_z_o
);

  logic  push, full, q_valid, q_pop;
  item_t front_item, q_item;

  cpi_front u_front (
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .start_new_track_i (start_new_track_i),
    .angle_alpha_i     (angle_alpha_i),
    .angle_beta_i      (angle_beta_i),
    .angle_gamma_i     (angle_gamma_i),
    .shift_a_i         (shift_a_i),
    .shift_b_i         (shift_b_i),
    .shift_c_i         (shift_c_i),
    .full_i            (full),
    .push_o            (push),
    .item_o            (front_item)
  );

  cpi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  cpi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .axis_i_x_o  (axis_i_x_o),
    .axis_i_y_o  (axis_i_y_o),
    .axis_i_z_o  (axis_i_z_o),
    .axis_j_x_o  (axis_j_x_o),
    .axis_j_y_o  (axis_j_y_o),
    .axis_j_z_o  (axis_j_z_o),
    .axis_k_x_o  (axis_k_x_o),
    .axis_k_y_o  (axis_k_y_o),
    .axis_k_z_o  (axis_k_z_o),
    .centre_x_o  (centre_x_o),
    .centre_y_o  (centre_y_o),
    .centre_z_o  (centre_z_o)
  );

endmodule

// ===== rtl/cpi_front.sv =====
module cpi_front import cpi_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_new_track_i,
  input  logic [15:0] angle_alpha_i,
  input  logic [15:0] angle_beta_i,
  input  logic [15:0] angle_gamma_i,
  input  logic [31:0] shift_a_i,
  input  logic [31:0] shift_b_i,
  input  logic [31:0] shift_c_i,
  input  logic        full_i,
  output logic        push_o,
  output item_t       item_o
);

  logic [31:0] phase [LANES];
  logic [31:0] biased [LANES];

  assign phase[LANE_ALPHA] = {{16{angle_alpha_i[15]}}, angle_alpha_i} << PHASE_SHIFT;
  assign phase[LANE_BETA]  = {{16{angle_beta_i[15]}}, angle_beta_i} << PHASE_SHIFT;
  assign phase[LANE_GAMMA] = {{16{angle_gamma_i[15]}}, angle_gamma_i} << PHASE_SHIFT;
  assign phase[LANE_DELTA] = phase[LANE_GAMMA] - phase[LANE_BETA];

  always_comb begin
    item_o.start    = start_new_track_i;
    item_o.shift[0] = shift_a_i;
    item_o.shift[1] = shift_b_i;
    item_o.shift[2] = shift_c_i;
    for (int l = 0; l < LANES; l++) begin
      biased[l]      = phase[l] + 32'h2000_0000;
      item_o.quad[l] = biased[l][31:30];
      item_o.z0[l]   = phase[l] - {biased[l][31:30], 30'b0};
    end
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

endmodule

// ===== rtl/cpi_fifo.sv =====
module cpi_fifo import cpi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/cpi_cordic.sv =====
module cpi_cordic import cpi_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [LANES-1:0][1:0]  quad_i,
  input  logic [LANES-1:0][31:0] z0_i,
  output logic                   done_o,
  output logic signed [32:0]     cos_o [LANES],
  output logic signed [32:0]     sin_o [LANES]
);

  localparam int IT_W = $clog2(CORDIC_ITERS);

  logic                   run_q, done_q;
  logic [IT_W-1:0]        it_q;
  logic signed [32:0]     x_q [LANES];
  logic signed [32:0]     y_q [LANES];
  logic signed [32:0]     z_q [LANES];
  logic [1:0]             quad_q [LANES];
  logic signed [32:0]     ang;
  logic                   last_it;

  assign ang     = $signed({1'b0, atan_at(5'(it_q))});
  assign last_it = (it_q == IT_W'(CORDIC_ITERS - 1));
  assign done_o  = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= run_q & last_it;
      if (start_i) begin
        run_q <= 1'b1;
        it_q  <= '0;
      end else if (run_q) begin
        it_q <= it_q + 1'b1;
        if (last_it) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      if (start_i) begin
        x_q[l]    <= CORDIC_X0;
        y_q[l]    <= '0;
        z_q[l]    <= 33'($signed(z0_i[l]));
        quad_q[l] <= quad_i[l];
      end else if (run_q) begin
        if (!z_q[l][32]) begin
          x_q[l] <= x_q[l] - (y_q[l] >>> it_q);
          y_q[l] <= y_q[l] + (x_q[l] >>> it_q);
          z_q[l] <= z_q[l] - ang;
        end else begin
          x_q[l] <= x_q[l] + (y_q[l] >>> it_q);
          y_q[l] <= y_q[l] - (x_q[l] >>> it_q);
          z_q[l] <= z_q[l] + ang;
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      case (quad_q[l])
        2'd0: begin
          cos_o[l] = x_q[l];
          sin_o[l] = y_q[l];
        end
        2'd1: begin
          cos_o[l] = -y_q[l];
          sin_o[l] = x_q[l];
        end
        2'd2: begin
          cos_o[l] = -x_q[l];
          sin_o[l] = -y_q[l];
        end
        default: begin
          cos_o[l] = y_q[l];
          sin_o[l] = -x_q[l];
        end
      endcase
    end
  end

endmodule

// ===== rtl/cpi_back.sv =====
module cpi_back import cpi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] axis_i_x_o,
  output logic [31:0] axis_i_y_o,
  output logic [31:0] axis_i_z_o,
  output logic [31:0] axis_j_x_o,
  output logic [31:0] axis_j_y_o,
  output logic [31:0] axis_j_z_o,
  output logic [31:0] axis_k_x_o,
  output logic [31:0] axis_k_y_o,
  output logic [31:0] axis_k_z_o,
  output logic [47:0] centre_x_o,
  output logic [47:0] centre_y_o,
  output logic [47:0] centre_z_o
);

  function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
    if (v > 56'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -56'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [55:0] v);
    if (v > 56'sh7FFF_FFFF_FFFF) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < -56'sh8000_0000_0000) begin
      return 48'sh8000_0000_0000;
    end
    return v[47:0];
  endfunction

  state_e state_q, state_d;
  op_t    op_q, op_next, wb_op_q;
  logic   wb_valid_q, out_valid_q;

  logic   pop, cordic_start, issue, out_free, load_out, op_last;
  logic   cordic_done;

  logic signed [32:0] cs [LANES];
  logic signed [32:0] sn [LANES];
  logic signed [33:0] oc;

  logic [31:0]        focal_q;
  item_t              item_q;
  logic signed [31:0] rot_q [9];
  logic signed [31:0] nr_q [9];
  logic signed [31:0] m_q [9];
  logic signed [47:0] cen_q [3];
  logic signed [48:0] t_q [3];
  logic signed [33:0] p1_q, p2_q;
  logic signed [56:0] hi_q;
  logic signed [55:0] acc_q;
  logic signed [67:0] prod_q;

  logic signed [33:0] mul_a, mul_b;
  logic signed [31:0] rsel;
  logic signed [48:0] tsel;

  logic signed [67:0] rnd30;
  logic signed [37:0] mq;
  logic signed [68:0] tneg;
  logic signed [57:0] lo_sum;
  logic signed [51:0] term;
  logic signed [55:0] acc_base, rm_sum, cen_sum;

  logic [31:0] ax_q [9];
  logic [47:0] ce_q [3];

  cpi_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .quad_i  (q_item_i.quad),
    .z0_i    (q_item_i.z0),
    .done_o  (cordic_done),
    .cos_o   (cs),
    .sin_o   (sn)
  );

  assign cfg_ready_o = 1'b1;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign op_last     = (op_q == OP_LAST);
  assign oc          = 34'(ONE_Q30) - 34'(cs[LANE_ALPHA]);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (q_valid_i) state_d = ST_TRIG;
      ST_TRIG: if (cordic_done) state_d = ST_MUL;
      ST_MUL:  if (op_last) state_d = ST_FIN;
      ST_FIN:  state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    cordic_start = 1'b0;
    issue        = 1'b0;
    load_out     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        pop          = q_valid_i;
        cordic_start = q_valid_i;
      end
      ST_MUL:  issue = 1'b1;
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  assign q_pop_o = pop;

  always_comb begin
    op_next = op_q;
    case (op_q.grp)
      GRP_TRIG: begin
        if (op_q.idx == TOP_M7) begin
          op_next = '{grp: GRP_RM, idx: 4'd0, k: 2'd0, half: 1'b0};
        end else begin
          op_next.idx = op_q.idx + 1'b1;
        end
      end
      GRP_RM: begin
        if (op_q.k != 2'd2) begin
          op_next.k = op_q.k + 1'b1;
        end else if (op_q.idx != 4'd8) begin
          op_next.k   = 2'd0;
          op_next.idx = op_q.idx + 1'b1;
        end else begin
          op_next = '{grp: GRP_TR, idx: 4'd0, k: 2'd0, half: 1'b0};
        end
      end
      GRP_TR: begin
        if (op_q.k != 2'd2) begin
          op_next.k = op_q.k + 1'b1;
        end else begin
          op_next = '{grp: GRP_CEN, idx: 4'd0, k: 2'd0, half: 1'b0};
        end
      end
      default: begin
        if (!op_q.half) begin
          op_next.half = 1'b1;
        end else if (op_q.k != 2'd2) begin
          op_next.half = 1'b0;
          op_next.k    = op_q.k + 1'b1;
        end else begin
          op_next.half = 1'b0;
          op_next.k    = 2'd0;
          op_next.idx  = op_q.idx + 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    rsel  = nr_q[ent(op_q.idx[1:0], op_q.k)];
    tsel  = t_q[op_q.k];
    case (op_q.grp)
      GRP_TRIG: begin
        case (op_q.idx)
          TOP_P1: begin mul_a = oc;                        mul_b = 34'(sn[LANE_GAMMA]); end
          TOP_P2: begin mul_a = oc;                        mul_b = 34'(cs[LANE_GAMMA]); end
          TOP_M2: begin mul_a = 34'(sn[LANE_GAMMA]);       mul_b = 34'(sn[LANE_ALPHA]); end
          TOP_M0: begin mul_a = p1_q;                      mul_b = 34'(sn[LANE_DELTA]); end
          TOP_M1: begin mul_a = p1_q;                      mul_b = 34'(cs[LANE_DELTA]); end
          TOP_M3: begin mul_a = p2_q;                      mul_b = 34'(sn[LANE_DELTA]); end
          TOP_M4: begin mul_a = p2_q;                      mul_b = 34'(cs[LANE_DELTA]); end
          TOP_M5: begin mul_a = 34'(cs[LANE_GAMMA]);       mul_b = 34'(sn[LANE_ALPHA]); end
          TOP_M6: begin mul_a = 34'(sn[LANE_ALPHA]);       mul_b = 34'(sn[LANE_DELTA]); end
          default: begin mul_a = 34'(sn[LANE_ALPHA]);      mul_b = 34'(cs[LANE_DELTA]); end
        endcase
      end
      GRP_RM: begin
        mul_a = 34'(rot_q[ent(row_of(op_q.idx), op_q.k)]);
        mul_b = 34'(m_q[ent(op_q.k, col_of(op_q.idx))]);
      end
      GRP_TR: begin
        mul_a = 34'($signed(item_q.shift[op_q.k]));
        mul_b = $signed({2'b00, focal_q});
      end
      default: begin
        mul_a = 34'(rsel);
        if (!op_q.half) begin
          mul_b = 34'($signed(tsel[48:24]));
        end else begin
          mul_b = $signed({10'b0, tsel[23:0]});
        end
      end
    endcase
  end

  assign rnd30    = prod_q + (68'sd1 <<< 29);
  assign mq       = rnd30[67:30];
  assign tneg     = 69'sd32768 - 69'(prod_q);
  assign lo_sum   = 58'(hi_q) + 58'($signed(rnd30[67:24]));
  assign term     = lo_sum[57:6];
  assign acc_base = (wb_op_q.k == 2'd0) ? '0 : acc_q;
  assign rm_sum   = acc_base + 56'(mq);
  assign cen_sum  = 56'(cen_q[wb_op_q.idx[1:0]]) + acc_base + 56'(term);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_FIRST;
      wb_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      focal_q     <= FOCAL_RESET;
      for (int e = 0; e < 9; e++) begin
        rot_q[e] <= (e == 0 || e == 4 || e == 8) ? ONE_Q30 : '0;
      end
      for (int e = 0; e < 3; e++) begin
        cen_q[e] <= '0;
      end
    end else begin
      state_q    <= state_d;
      wb_valid_q <= issue;
      if (state_q == ST_TRIG) begin
        op_q <= OP_FIRST;
      end else if (issue) begin
        op_q <= op_next;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        focal_q <= cfg_data_i;
      end
      if (pop && q_item_i.start) begin
        for (int e = 0; e < 9; e++) begin
          rot_q[e] <= (e == 0 || e == 4 || e == 8) ? ONE_Q30 : '0;
        end
        for (int e = 0; e < 3; e++) begin
          cen_q[e] <= '0;
        end
      end else if (state_q == ST_DONE) begin
        for (int e = 0; e < 9; e++) begin
          rot_q[e] <= nr_q[e];
        end
      end
      if (wb_valid_q && wb_op_q.grp == GRP_CEN && wb_op_q.half && wb_op_q.k == 2'd2) begin
        cen_q[wb_op_q.idx[1:0]] <= sat48(cen_sum);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      item_q <= q_item_i;
    end
    if (state_q == ST_TRIG && cordic_done) begin
      m_q[8] <= sat32(56'(cs[LANE_ALPHA]));
    end
    wb_op_q <= op_q;
    prod_q  <= mul_a * mul_b;
    if (wb_valid_q) begin
      case (wb_op_q.grp)
        GRP_TRIG: begin
          case (wb_op_q.idx)
            TOP_P1: p1_q <= mq[33:0];
            TOP_P2: p2_q <= mq[33:0];
            TOP_M2: m_q[2] <= sat32(56'(mq));
            TOP_M0: m_q[0] <= sat32(56'(cs[LANE_BETA]) - 56'(mq));
            TOP_M1: m_q[1] <= sat32(56'(mq) - 56'(sn[LANE_BETA]));
            TOP_M3: m_q[3] <= sat32(56'(sn[LANE_BETA]) + 56'(mq));
            TOP_M4: m_q[4] <= sat32(56'(cs[LANE_BETA]) - 56'(mq));
            TOP_M5: m_q[5] <= sat32(-56'(mq));
            TOP_M6: m_q[6] <= sat32(-56'(mq));
            default: m_q[7] <= sat32(56'(mq));
          endcase
        end
        GRP_RM: begin
          acc_q <= rm_sum;
          if (wb_op_q.k == 2'd2) begin
            nr_q[wb_op_q.idx] <= sat32(rm_sum);
          end
        end
        GRP_TR: t_q[wb_op_q.k] <= tneg[64:16];
        default: begin
          if (!wb_op_q.half) begin
            hi_q <= prod_q[56:0];
          end else begin
            acc_q <= acc_base + 56'(term);
          end
        end
      endcase
    end
    if (load_out) begin
      for (int e = 0; e < 9; e++) begin
        ax_q[e] <= nr_q[e];
      end
      for (int e = 0; e < 3; e++) begin
        ce_q[e] <= cen_q[e];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign axis_i_x_o  = ax_q[0];
  assign axis_i_y_o  = ax_q[3];
  assign axis_i_z_o  = ax_q[6];
  assign axis_j_x_o  = ax_q[1];
  assign axis_j_y_o  = ax_q[4];
  assign axis_j_z_o  = ax_q[7];
  assign axis_k_x_o  = ax_q[2];
  assign axis_k_y_o  = ax_q[5];
  assign axis_k_z_o  = ax_q[8];
  assign centre_x_o  = ce_q[0];
  assign centre_y_o  = ce_q[1];
  assign centre_z_o  = ce_q[2];

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpi_pkg::*;

  localparam int  CYCLE_LIMIT = 1_000_000;
  localparam int  DRAIN_WAIT  = 120;
  localparam int  HOLD_LEN    = 500;
  localparam longint CEN_MAX  = 64'sd140737488355327;

  typedef struct {
    bit          start;
    logic [15:0] alpha, beta, gamma;
    logic [31:0] sh[3];
  } motion_t;

  typedef struct {
    logic [31:0] axis[9];
    logic [47:0] cen[3];
  } pose_t;

  class pose_scoreboard;
    longint rot[9];
    longint cen[3];
    longint focal;
    pose_t  pending[$];
    int     errors;
    longint atan_q[30] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
      'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};
    string names[12] = '{"axis_i_x", "axis_i_y", "axis_i_z", "axis_j_x", "axis_j_y",
      "axis_j_z", "axis_k_x", "axis_k_y", "axis_k_z", "centre_x", "centre_y", "centre_z"};

    function void clear_track();
      for (int k = 0; k < 9; k++) rot[k] = (k % 4 == 0) ? 64'sd1073741824 : 0;
      for (int k = 0; k < 3; k++) cen[k] = 0;
    endfunction

    function new();
      clear_track();
      focal = FOCAL_RESET;
      errors = 0;
    endfunction

    function longint sat32(longint v);
      return v < -64'sd2147483648 ? -64'sd2147483648 : (v > 64'sd2147483647 ? 64'sd2147483647 : v);
    endfunction

    function longint mul_q30(longint a, longint b);
      return (a * b + 64'sd536870912) >>> 30;
    endfunction

    function longint mul_rt(longint r, longint t);
      logic signed [127:0] a, b, p;
      a = r;
      b = t;
      p = a * b + 128'sd536870912;
      p = p >>> 30;
      return p[63:0];
    endfunction

    function void sin_cos(logic [31:0] ph, output longint c, output longint s);
      logic [31:0] q, rem;
      longint x, y, z, dx, dy;
      q = ((ph + 32'h2000_0000) >> 30) & 32'd3;
      rem = ph - (q << 30);
      z = $signed(rem);
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_q[i];
        end else begin
          x += dx; y -= dy; z += atan_q[i];
        end
      end
      case (q[1:0])
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function logic [31:0] phase_of(logic [15:0] a);
      longint v;
      v = $signed(a);
      return 32'(v << PHASE_SHIFT);
    endfunction

    function void note_motion(motion_t mv);
      longint ca, sa, cb, sb, cg, sg, cd, sd, oc, acc, shv;
      longint m[9], nr[9], t[3];
      logic [31:0] pb, pg;
      pose_t e;
      if (mv.start) clear_track();
      pb = phase_of(mv.beta);
      pg = phase_of(mv.gamma);
      sin_cos(phase_of(mv.alpha), ca, sa);
      sin_cos(pb, cb, sb);
      sin_cos(pg, cg, sg);
      sin_cos(pg - pb, cd, sd);
      oc = 64'sd1073741824 - ca;
      m[0] = sat32(cb - mul_q30(mul_q30(oc, sg), sd));
      m[1] = sat32(-sb + mul_q30(mul_q30(oc, sg), cd));
      m[2] = sat32(mul_q30(sg, sa));
      m[3] = sat32(sb + mul_q30(mul_q30(oc, cg), sd));
      m[4] = sat32(cb - mul_q30(mul_q30(oc, cg), cd));
      m[5] = sat32(-mul_q30(cg, sa));
      m[6] = sat32(-mul_q30(sa, sd));
      m[7] = sat32(mul_q30(sa, cd));
      m[8] = sat32(ca);
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += mul_q30(rot[r*3+k], m[k*3+c]);
          nr[r*3+c] = sat32(acc);
        end
      rot = nr;
      for (int k = 0; k < 3; k++) begin
        shv = $signed(mv.sh[k]);
        t[k] = (-(shv * focal) + 64'sd32768) >>> 16;
      end
      for (int r = 0; r < 3; r++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += mul_rt(rot[r*3+k], t[k]);
        acc += cen[r];
        cen[r] = acc > CEN_MAX ? CEN_MAX : (acc < -CEN_MAX - 1 ? -CEN_MAX - 1 : acc);
      end
      for (int c = 0; c < 3; c++)
        for (int r = 0; r < 3; r++) e.axis[c*3+r] = rot[r*3+c][31:0];
      for (int k = 0; k < 3; k++) e.cen[k] = cen[k][47:0];
      pending.push_back(e);
    endfunction

    function void check_pose(pose_t got);
      pose_t e;
      if (pending.size() == 0) begin
        $error("pose transaction with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int k = 0; k < 9; k++)
        if (got.axis[k] !== e.axis[k]) begin
          $error("%s expected %h got %h", names[k], e.axis[k], got.axis[k]);
          errors++;
        end
      for (int k = 0; k < 3; k++)
        if (got.cen[k] !== e.cen[k]) begin
          $error("%s expected %h got %h", names[9+k], e.cen[k], got.cen[k]);
          errors++;
        end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic in_valid_i, in_stall_o, start_new_track_i;
  logic [15:0] angle_alpha_i, angle_beta_i, angle_gamma_i;
  logic [31:0] shift_a_i, shift_b_i, shift_c_i;
  logic out_valid_o, out_stall_i;
  logic [31:0] axis_i_x_o, axis_i_y_o, axis_i_z_o, axis_j_x_o, axis_j_y_o, axis_j_z_o;
  logic [31:0] axis_k_x_o, axis_k_y_o, axis_k_z_o;
  logic [47:0] centre_x_o, centre_y_o, centre_z_o;

  camera_pose_integrator u_top (.*);

  pose_scoreboard sb = new();
  bit     quiet_tail;
  int     poses_seen;
  longint cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold
  initial begin
    int hold_left;
    bit held;
    out_stall_i = 1'b0;
    hold_left = 0;
    held = 1'b0;
    poses_seen = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        pose_t got;
        got.axis = '{axis_i_x_o, axis_i_y_o, axis_i_z_o, axis_j_x_o, axis_j_y_o,
                     axis_j_z_o, axis_k_x_o, axis_k_y_o, axis_k_z_o};
        got.cen = '{centre_x_o, centre_y_o, centre_z_o};
        sb.check_pose(got);
        poses_seen++;
      end
      if (!held && poses_seen == 200) begin
        held = 1'b1;
        hold_left = HOLD_LEN;
      end else if (hold_left == 0 && !quiet_tail && $urandom_range(0, 9) == 0)
        hold_left = $urandom_range(1, 4);
      if (quiet_tail && hold_left <= 4) hold_left = 0;
      out_stall_i <= (hold_left > 0);
      if (hold_left > 0) hold_left--;
    end
  end

  task automatic write_focal(logic [31:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.focal = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_motion(motion_t mv);
    int gap;
    in_valid_i        <= 1'b1;
    start_new_track_i <= mv.start;
    angle_alpha_i     <= mv.alpha;
    angle_beta_i      <= mv.beta;
    angle_gamma_i     <= mv.gamma;
    shift_a_i         <= mv.sh[0];
    shift_b_i         <= mv.sh[1];
    shift_c_i         <= mv.sh[2];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_motion(mv);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic motion_t make(bit s, logic [15:0] a, logic [15:0] b, logic [15:0] g,
                                   logic [31:0] x, logic [31:0] y, logic [31:0] z);
    motion_t mv;
    mv.start = s; mv.alpha = a; mv.beta = b; mv.gamma = g;
    mv.sh = '{x, y, z};
    return mv;
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 16'($signed($urandom_range(0, 256)) - 128);
      1: return {2'($urandom_range(0, 3)), 14'h0} + 16'($urandom_range(0, 7)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_shift();
    case ($urandom_range(0, 3))
      0: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_run(int n);
    motion_t mv;
    for (int i = 0; i < n; i++) begin
      mv = make($urandom_range(0, 19) == 0, rand_angle(), rand_angle(), rand_angle(),
                rand_shift(), rand_shift(), rand_shift());
      send_motion(mv);
      if (i == n / 2 && n > 100) drain();
    end
    drain();
  endtask

  initial begin
    logic [31:0] focals[4];
    quiet_tail = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    start_new_track_i = 1'b0;
    angle_alpha_i = '0;
    angle_beta_i = '0;
    angle_gamma_i = '0;
    shift_a_i = '0;
    shift_b_i = '0;
    shift_c_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_motion(make(0, 16'h0000, 16'h0000, 16'h0000, 32'h0001_0000, 0, 0));
    send_motion(make(0, 16'h7fff, 16'h8000, 16'h7fff, 32'h7fff_ffff, 32'h8000_0000, 0));
    send_motion(make(0, 16'h4000, 16'hc000, 16'h2000, 32'hffff_ffff, 1, 32'h7fff_ffff));
    send_motion(make(1, 16'h2000, 16'he000, 16'h6000, 0, 0, 0));
    send_motion(make(0, 16'h8000, 16'h4000, 16'hc000, 32'h8000_0000, 32'h8000_0000, 1));
    send_motion(make(1, 16'hffff, 16'h0001, 16'h1fff, 32'h1234_5678, 32'hedcb_a988, 0));
    send_motion(make(0, 16'ha000, 16'h5fff, 16'h8000, 32'h0000_8000, 32'hffff_8000, 0));
    drain();
    write_focal(32'hffff_ffff);
    for (int i = 0; i < 6; i++)
      send_motion(make(i == 0, 16'h0000, 16'h0000, 16'h0000, 32'h7fff_ffff,
                       32'h8000_0000, 32'h7fff_ffff));
    for (int i = 0; i < 4; i++)
      send_motion(make(0, 16'h1000, 16'h3000, 16'h5000, 32'h8000_0000, 32'h7fff_ffff, 0));
    drain();
    write_focal(32'h0000_0000);
    send_motion(make(1, 16'h1234, 16'h4321, 16'hbeef, 32'h7fff_ffff, 32'h8000_0000, 5));
    drain();
    write_focal(FOCAL_RESET);

    focals = '{32'h0001_0000, 32'h0000_0000, 32'hffff_ffff, $urandom};
    for (int ph = 0; ph < 4; ph++) begin
      write_focal(focals[ph]);
      if (ph == 3) quiet_tail = 1'b1;
      random_run(ph == 3 ? 250 : 300);
    end

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== camera_pose_integrator.f =====
rtl/cpi_pkg.sv
rtl/cpi_front.sv
rtl/cpi_fifo.sv
rtl/cpi_cordic.sv
rtl/cpi_back.sv
rtl/camera_pose_integrator.sv
tb/tb.sv
